>>> rtl/assert_macros.svh
// Assertion macros used by the RTL core of the 3x3 box-sum block.
// Each use expects the signals clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_CHK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> rtl/cvbs_pkg.sv
// Constants, widths and register codes of the 3x3 box-sum cost aggregator.
// No dependencies; used by the channel interfaces and the core.
package cvbs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COST_BITS  = 16;

	// Register and field widths.
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int AGG_W      = 23;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;

	localparam int FRAME_WIDTH_RST  = 1024;
	localparam int FRAME_HEIGHT_RST = 1024;

	// Derived internal widths.
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int EW_W      = $clog2(MAX_WIDTH + 1);
	localparam int EH_W      = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W     = $clog2(MAX_HEIGHT + 2);
	localparam int PIX_W     = COST_BITS + 2;
	localparam int CSUM_W    = COST_BITS + 4;
	localparam int PAIR_W    = CSUM_W + 1;
	localparam int AGG_SUM_W = PAIR_W + 3;
	localparam int LINE_W    = 2 * PIX_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = CFG_IDX_W'(0),
		REG_FRAME_HEIGHT = CFG_IDX_W'(1)
	} cfg_reg_t;

endpackage

>>> rtl/cvbs_ifs.sv
// Valid/ready channel interfaces of the 3x3 box-sum block: pixel input,
// aggregated result output and configuration writes. Depends on cvbs_pkg.
interface cvbs_in_if import cvbs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [COST_BITS-1:0] cost_y;
	logic [COST_BITS-1:0] cost_cr;
	logic [COST_BITS-1:0] cost_cb;
	logic                 is_pad;

	modport source (output valid, cost_y, cost_cr, cost_cb, is_pad, input ready);
	modport sink (input valid, cost_y, cost_cr, cost_cb, is_pad, output ready);
endinterface

interface cvbs_out_if import cvbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [AGG_W-1:0] agg_cost;
	logic             end_of_frame;

	modport source (output valid, agg_cost, end_of_frame, input ready);
	modport sink (input valid, agg_cost, end_of_frame, output ready);
endinterface

interface cvbs_cfg_if import cvbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cost_volume_box_sum_3x3_core.sv
// 3x3 box-sum cost aggregator core: line-buffer RAM, column window, output.
// Depends on cvbs_pkg, the interfaces in cvbs_ifs.sv, cvbs_ram, assert_macros.svh.
//
// Usage: pixels of one cost plane arrive in raster order on the pixel channel,
// one request per pixel carrying the Y, Cr and Cb costs. Each result request
// on the result channel carries three times the in-frame 3x3 sum around one
// pixel. Results trail the input by one row plus one pixel; after the last
// pixel, frame_width + 1 pad requests flush the remaining results, and the
// last one is flagged with end_of_frame. A pad request at the start of a frame
// is dropped. Configuration writes (frame_width, frame_height) restart the frame;
// the user issues them only while the block is idle, which it does not enforce.
//
// Throughput: one pixel request per cycle, sustained while the receiver does
// not stall. The two previous rows live in a single RAM of paired entries that
// is read once and written once per pixel; that one read port and one write
// port set the rate. A result leaves the output register once the request that
// completes its window has passed stage 1 (RAM read, window) and stage 2.
// Reset: position, window and pipeline are cleared, frame_width and
// frame_height return to 1024; the line RAM is not cleared and needs no pass.
// Stalls: the output register holds its result while the receiver stalls;
// the pipeline behind it keeps accepting until its stages are full.
`include "assert_macros.svh"

module cost_volume_box_sum_3x3_core import cvbs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cvbs_cfg_if.sink  cfg,
	cvbs_in_if.sink   pixel,
	cvbs_out_if.source result
);

	// Configuration registers.
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic            cfg_we;
	logic            restart;
	logic [EW_W-1:0] eff_w;
	logic [EH_W-1:0] eff_h;

	// Input position.
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	// Stage 0 decode.
	logic             take;
	logic             idle_pad;
	logic             live;
	logic [COL_W-1:0] col_eff;
	logic             col_zero;
	logic             last_col;
	logic             row_ge1;
	logic             row_ge2;
	logic             res_col0;
	logic             res_win;
	logic             eof;
	logic [PIX_W-1:0] pix_in;
	logic [ROW_W-1:0] last_row;

	// Line RAM ports.
	logic              ram_we;
	logic [COL_W-1:0]  ram_wa;
	logic [LINE_W-1:0] ram_wd;
	logic              ram_re;
	logic [COL_W-1:0]  ram_ra;
	logic [LINE_W-1:0] ram_rd;

	// Stage 1: RAM data returns, column sum and window update.
	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic              ge1_s1;
	logic              ge2_s1;
	logic              czero_s1;
	logic              rcol0_s1;
	logic              rwin_s1;
	logic              eof_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_data_s1;
	logic [LINE_W-1:0] line_s1;
	logic [PIX_W-1:0]  up_rd;
	logic [PIX_W-1:0]  mid_rd;
	logic [CSUM_W-1:0] colsum;
	logic [PAIR_W-1:0] pair;
	logic              has_res_s1;
	logic              s1_move;

	// Window of column sums; the oldest column only ever feeds a result
	// through the pair sum, so the two newer columns are all that is kept.
	logic [CSUM_W-1:0] wc1_q;
	logic [CSUM_W-1:0] wc2_q;

	// Stage 2: result operands.
	logic              valid_s2;
	logic [PAIR_W-1:0] pair_s2;
	logic [CSUM_W-1:0] csum_s2;
	logic              eof_s2;
	logic              s2_free;
	logic              s2_move;

	// Output register.
	logic                 out_valid_q;
	logic [AGG_W-1:0]     agg_q;
	logic                 eof_q;
	logic                 out_free;
	logic [AGG_SUM_W-1:0] sum3;
	logic [AGG_SUM_W-1:0] agg_full;

	// ------------------------------------------------------------------
	// Configuration. The port is always ready; writes beyond the register
	// list are taken and ignored.
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH:  restart = 1'b1;
				REG_FRAME_HEIGHT: restart = 1'b1;
				default:          restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(FRAME_WIDTH_RST);
			frame_height_q <= FH_W'(FRAME_HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg.data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg.data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero register acts as one, and values past the maximum clamp to it.
	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = EW_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = EW_W'(MAX_WIDTH);
		end else begin
			eff_w = EW_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = EH_W'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			eff_h = EH_W'(MAX_HEIGHT);
		end else begin
			eff_h = EH_W'(frame_height_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: position decode and channel sum at acceptance.
	// ------------------------------------------------------------------
	assign idle_pad = pixel.is_pad && (row_q == '0) && (col_q == '0);
	assign take     = pixel.valid && pixel.ready && !idle_pad;
	assign col_eff  = (EW_W'(col_q) >= eff_w) ? '0 : col_q;
	assign col_zero = (col_eff == '0);
	assign last_col = (EW_W'(col_eff) + EW_W'(1)) >= eff_w;
	assign row_ge1  = (row_q != '0);
	assign row_ge2  = (row_q[ROW_W-1:1] != '0);
	assign last_row = ROW_W'(eff_h) + ROW_W'(1);
	assign res_col0 = col_zero && row_ge2;
	assign res_win  = !col_zero && row_ge1;
	assign eof      = res_col0 && (row_q == last_row);

	// Pads inside the frame and anything in the flush rows count as zero.
	assign live   = !pixel.is_pad && (row_q < ROW_W'(eff_h));
	assign pix_in = live ? (PIX_W'(pixel.cost_y) + PIX_W'(pixel.cost_cr)
		+ PIX_W'(pixel.cost_cb)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (eof) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= row_q + ROW_W'(1);
				col_q <= '0;
			end else begin
				col_q <= col_eff + COL_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Line RAM: each entry holds {upper row, middle row} for one column.
	// It is read when a pixel is accepted and written back when that pixel
	// leaves stage 1. With a one-pixel row, the entry being written is the
	// one just read, so the written word is forwarded into stage 1.
	// ------------------------------------------------------------------
	assign ram_re = take;
	assign ram_ra = col_eff;
	assign ram_we = s1_move;
	assign ram_wa = col_s1;
	assign ram_wd = {mid_rd, pix_s1};

	cvbs_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we (ram_we),
		.wa (ram_wa),
		.wd (ram_wd),
		.re (ram_re),
		.ra (ram_ra),
		.rd (ram_rd)
	);

	// ------------------------------------------------------------------
	// Stage 1.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_s1      <= col_eff;
			pix_s1      <= pix_in;
			ge1_s1      <= row_ge1;
			ge2_s1      <= row_ge2;
			czero_s1    <= col_zero;
			rcol0_s1    <= res_col0;
			rwin_s1     <= res_win;
			eof_s1      <= eof;
			fwd_s1      <= ram_we && (ram_wa == col_eff);
			fwd_data_s1 <= ram_wd;
		end
	end

	assign line_s1 = fwd_s1 ? fwd_data_s1 : ram_rd;
	assign up_rd   = line_s1[LINE_W-1:PIX_W];
	assign mid_rd  = line_s1[PIX_W-1:0];

	// Rows above the frame top read as zero; the RAM there is stale.
	assign colsum = CSUM_W'(pix_s1)
		+ (ge1_s1 ? CSUM_W'(mid_rd) : CSUM_W'(0))
		+ (ge2_s1 ? CSUM_W'(up_rd) : CSUM_W'(0));
	assign pair   = PAIR_W'(wc1_q) + PAIR_W'(wc2_q);

	assign has_res_s1  = rcol0_s1 || rwin_s1;
	assign s1_move     = valid_s1 && (!has_res_s1 || s2_free);
	assign pixel.ready = !valid_s1 || s1_move;

	// A new row starts with an empty window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc1_q <= '0;
			wc2_q <= '0;
		end else if (restart) begin
			wc1_q <= '0;
			wc2_q <= '0;
		end else if (s1_move) begin
			wc1_q <= czero_s1 ? CSUM_W'(0) : wc2_q;
			wc2_q <= colsum;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2. A row-start result covers only the two held columns; an
	// in-row result adds the fresh column sum.
	// ------------------------------------------------------------------
	assign s2_free = !valid_s2 || out_free;
	assign s2_move = valid_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move && has_res_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && has_res_s1) begin
			pair_s2 <= pair;
			csum_s2 <= rwin_s1 ? colsum : CSUM_W'(0);
			eof_s2  <= eof_s1;
		end
	end

	// ------------------------------------------------------------------
	// Output register: three times the window sum as sum + 2 * sum.
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || result.ready;
	assign sum3     = AGG_SUM_W'(pair_s2) + AGG_SUM_W'(csum_s2);
	assign agg_full = sum3 + (sum3 << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			agg_q <= AGG_W'(agg_full);
			eof_q <= eof_s2;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.agg_cost     = agg_q;
	assign result.end_of_frame = eof_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// A read of the entry written in the same cycle must take the bypass.
	`ASSERT_CHK(a_fwd_same_entry, ram_we && ram_re && (ram_wa == ram_ra) |=> fwd_s1)
	// The frame ends only on a row-start result of the second flush row.
	`ASSERT_CHK(a_eof_row_start, valid_s1 && eof_s1 |-> rcol0_s1 && czero_s1)
	// The row counter never runs past the flush rows.
	`ASSERT_NEVER(a_row_bound, row_q > last_row)

endmodule

>>> rtl/cvbs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents.
module cvbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd <= mem[ra];
		end
	end

endmodule

>>> sim/box_sum_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 3x3 box-sum cost aggregator. It watches the register,
// pixel and result channels, predicts every aggregated cost and compares.
// Depends on cvbs_pkg and the channel interfaces in cvbs_ifs.sv.
module box_sum_checker import cvbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cvbs_cfg_if         cfg,
	cvbs_in_if          pixel,
	cvbs_out_if         result,
	output int unsigned mismatch_count,
	output int unsigned pending_results
);

	typedef struct packed {
		logic [AGG_W-1:0] agg_cost;
		logic             end_of_frame;
	} box_result_t;

	logic [FW_W-1:0]   width_reg;
	logic [FH_W-1:0]   height_reg;
	logic [PIX_W-1:0]  upper_costs [MAX_WIDTH];
	logic [PIX_W-1:0]  middle_costs [MAX_WIDTH];
	logic [CSUM_W-1:0] column_sums [3];
	int unsigned       row_pos;
	int unsigned       col_pos;
	box_result_t       expected_sums [$];

	function automatic int unsigned active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == 0)
			return 1;
		if (height_reg > MAX_HEIGHT)
			return MAX_HEIGHT;
		return 32'(height_reg);
	endfunction

	task automatic restart_frame();
		row_pos = 0;
		col_pos = 0;
		for (int i = 0; i < 3; i++)
			column_sums[i] = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		mismatch_count++;
		$display("%0t ns box sum mismatch on %s: got %0d, want %0d", $time, what, seen, wanted);
	endtask

	// Any write to a known register restarts the frame; other indexes are dropped.
	task automatic apply_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		if (index == REG_FRAME_WIDTH) begin
			width_reg = data[FW_W-1:0];
			restart_frame();
		end else if (index == REG_FRAME_HEIGHT) begin
			height_reg = data[FH_W-1:0];
			restart_frame();
		end
	endtask

	task automatic aggregate_pixel(input logic [COST_BITS-1:0] cost_y, cost_cr, cost_cb,
			input logic is_pad);
		int unsigned      cols;
		int unsigned      rows;
		int unsigned      c;
		int unsigned      r;
		logic [PIX_W-1:0] pix;
		logic [CSUM_W-1:0] csum;
		logic [31:0]      agg;
		bit               emit;
		bit               eof;
		box_result_t      item;
		cols = active_width();
		rows = active_height();
		c = col_pos;
		r = row_pos;
		pix = '0;
		agg = '0;
		emit = 1'b0;
		eof = 1'b0;
		// A pad at the very start of a frame is dropped without effect.
		if (is_pad && r == 0 && c == 0)
			return;
		if (c >= cols)
			c = 0;
		if (!is_pad && r < rows)
			pix = PIX_W'(cost_y) + PIX_W'(cost_cr) + PIX_W'(cost_cb);
		// The first column releases the last pixel of the row before last.
		if (c == 0) begin
			if (r >= 2) begin
				agg = 3 * (column_sums[1] + column_sums[2]);
				emit = 1'b1;
				eof = (r == rows + 1);
			end
			for (int i = 0; i < 3; i++)
				column_sums[i] = '0;
		end
		csum = CSUM_W'(pix);
		if (r >= 1)
			csum = csum + CSUM_W'(middle_costs[c]);
		if (r >= 2)
			csum = csum + CSUM_W'(upper_costs[c]);
		upper_costs[c] = middle_costs[c];
		middle_costs[c] = pix;
		column_sums[0] = column_sums[1];
		column_sums[1] = column_sums[2];
		column_sums[2] = csum;
		if (c >= 1 && r >= 1) begin
			agg = 3 * (column_sums[0] + column_sums[1] + column_sums[2]);
			emit = 1'b1;
		end
		if (emit) begin
			item.agg_cost = AGG_W'(agg);
			item.end_of_frame = eof;
			expected_sums.push_back(item);
		end
		if (eof) begin
			restart_frame();
		end else if (c + 1 >= cols) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic check_result(input logic [AGG_W-1:0] agg_cost, input logic end_of_frame);
		box_result_t want;
		if (expected_sums.size() == 0) begin
			report_mismatch("unexpected result", 32'(agg_cost), 0);
			return;
		end
		want = expected_sums.pop_front();
		if (agg_cost !== want.agg_cost)
			report_mismatch("agg_cost", 32'(agg_cost), 32'(want.agg_cost));
		if (end_of_frame !== want.end_of_frame)
			report_mismatch("end_of_frame", 32'(end_of_frame), 32'(want.end_of_frame));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_count = 0;
			width_reg = FW_W'(FRAME_WIDTH_RST);
			height_reg = FH_W'(FRAME_HEIGHT_RST);
			restart_frame();
			expected_sums.delete();
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
				apply_register(cfg.index, cfg.data);
			if (pixel.valid === 1'b1 && pixel.ready === 1'b1)
				aggregate_pixel(pixel.cost_y, pixel.cost_cr, pixel.cost_cb, pixel.is_pad);
			if (result.valid === 1'b1 && result.ready === 1'b1)
				check_result(result.agg_cost, result.end_of_frame);
		end
		pending_results = expected_sums.size();
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the 3x3 box-sum cost aggregator testbench: clock, reset, stimulus
// and verdict. Depends on cvbs_pkg, cvbs_ifs.sv, the core and box_sum_checker.sv.
module testbench;
	import cvbs_pkg::*;

	// An index that maps to no register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);
	// Margin after the last expected result, well above the pipeline depth.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 500;

	typedef enum int {
		COST_RANDOM,
		COST_MAX,
		COST_ZERO
	} cost_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	bit          idling_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned random_items = 0;
	int unsigned mismatches;
	int unsigned pending;

	cvbs_cfg_if cfg_ch();
	cvbs_in_if  pixel_ch();
	cvbs_out_if result_ch();

	cost_volume_box_sum_3x3_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pixel  (pixel_ch),
		.result (result_ch)
	);

	box_sum_checker box_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_ch),
		.pixel           (pixel_ch),
		.result          (result_ch),
		.mismatch_count  (mismatches),
		.pending_results (pending)
	);

	always #5 clk = ~clk;

	// Result side: the receiver stalls at random while idling is on, and is
	// always ready once it is switched off.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				result_ch.ready = 1'b0;
			end else begin
				if (stall_left == 0 && idling_on && $urandom_range(0, 11) == 0)
					stall_left = $urandom_range(1, 15);
				if (stall_left != 0) begin
					result_ch.ready = 1'b0;
					stall_left--;
				end else begin
					result_ch.ready = 1'b1;
				end
			end
		end
	end

	// Run limit, several times the slowest plausible run with full idling.
	initial begin
		#15_000_000;
		$display("cost_volume_box_sum_3x3_core verification failed");
		$finish;
	end

	// Cost values lean toward the two extremes so that the widest sums appear.
	function automatic logic [COST_BITS-1:0] pick_cost(input cost_pattern_t pattern);
		case (pattern)
			COST_MAX: return '1;
			COST_ZERO: return '0;
			default: begin
				case ($urandom_range(0, 9))
					0: return '0;
					1: return '1;
					default: return COST_BITS'($urandom);
				endcase
			end
		endcase
	endfunction

	// Present one pixel request and hold it until the block takes it. Valid stays
	// high on return so that the next request follows back to back; a random gap
	// lowers it first.
	task automatic send_pixel(input logic [COST_BITS-1:0] cost_y, cost_cr, cost_cb,
			input logic is_pad);
		if (idling_on && $urandom_range(0, 9) == 0) begin
			pixel_ch.valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		pixel_ch.valid = 1'b1;
		pixel_ch.cost_y = cost_y;
		pixel_ch.cost_cr = cost_cr;
		pixel_ch.cost_cb = cost_cb;
		pixel_ch.is_pad = is_pad;
		@(posedge clk);
		while (!pixel_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending and wait for every expected result. With settle set, the settle
	// margin passes as well, so that requests that produce no result are finished too.
	task automatic wait_idle(input bit settle);
		pixel_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only once the block has gone quiet.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		wait_idle(1'b1);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = index;
		cfg_ch.data = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_DATA_W-1:0] width_data,
			input logic [CFG_DATA_W-1:0] height_data);
		write_register(REG_FRAME_WIDTH, width_data);
		write_register(REG_FRAME_HEIGHT, height_data);
	endtask

	// One frame of cols x rows pixels followed by the cols + 1 flush requests.
	// Pads are mixed into the pixels at 1 in pad_odds (never if zero), and a
	// sixth of the flush requests carry real costs, which the block must ignore.
	// A nonzero cut_at ends the sequence early after that many requests, which
	// leaves the frame unfinished; a nonzero hold_at makes the sender wait for
	// all outstanding results just before that pixel.
	task automatic run_frame(input int unsigned cols, input int unsigned rows,
			input cost_pattern_t pattern, input int unsigned pad_odds,
			input int unsigned cut_at, input int unsigned hold_at);
		int unsigned pixels;
		int unsigned total;
		logic        is_pad;
		pixels = cols * rows;
		total = (cut_at != 0) ? cut_at : pixels + cols + 1;
		for (int unsigned i = 0; i < total; i++) begin
			if (hold_at != 0 && i == hold_at)
				wait_idle(1'b0);
			if (i < pixels)
				is_pad = (pad_odds != 0 && $urandom_range(1, pad_odds) == 1);
			else
				is_pad = ($urandom_range(0, 5) != 0);
			send_pixel(pick_cost(pattern), pick_cost(pattern), pick_cost(pattern), is_pad);
		end
		random_items += total;
	endtask

	initial begin
		int unsigned                 cols;
		int unsigned                 rows;
		int unsigned                 frames;
		int unsigned                 cut_at;
		int unsigned                 hold_at;
		logic [CFG_DATA_W-1:0]       width_data;

		// Every block input is known from time zero, before reset is released.
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		pixel_ch.valid = 1'b0;
		pixel_ch.cost_y = '0;
		pixel_ch.cost_cr = '0;
		pixel_ch.cost_cb = '0;
		pixel_ch.is_pad = 1'b0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The reset geometry is 1024 x 1024: a short stretch of the first row
		// gives no results, and reconfiguring then restarts the frame mid-row.
		repeat (12)
			send_pixel(pick_cost(COST_RANDOM), pick_cost(COST_RANDOM),
				pick_cost(COST_RANDOM), 1'b0);

		// 3x3 frame at full cost: the centre sum is the largest the block can
		// give. A pad ahead of the frame is dropped, and the first flush request
		// carries real costs that must be ignored.
		set_frame(3, 3);
		send_pixel('1, '1, '1, 1'b1);
		repeat (9)
			send_pixel('1, '1, '1, 1'b0);
		send_pixel('1, '1, '1, 1'b0);
		repeat (3)
			send_pixel('0, '0, '0, 1'b1);

		// 2x2 frame with a pad inside the frame, which counts as zero cost.
		set_frame(2, 2);
		send_pixel('1, '1, '1, 1'b0);
		send_pixel('1, '1, '1, 1'b1);
		send_pixel('0, '0, '0, 1'b0);
		send_pixel('1, '0, '1, 1'b0);
		repeat (3)
			send_pixel('0, '0, '0, 1'b1);

		// Zero width and height both act as one.
		set_frame(0, 0);
		send_pixel('1, '1, '1, 1'b0);
		repeat (2)
			send_pixel('1, '1, '1, 1'b1);

		// All-ones register data: the width field saturates at the line length
		// and the height at its maximum, each on its own with the other at one.
		// Only the opening stretch of each frame is sent; the next write
		// restarts it.
		set_frame('1, 1);
		run_frame(MAX_WIDTH, 1, COST_RANDOM, 12, 40, 0);
		set_frame(1, '1);
		run_frame(1, MAX_HEIGHT, COST_RANDOM, 12, 40, 0);

		// Random geometry, mostly well-formed frames with random content, some
		// of them cut short or flushed short, plus stray pads and spare writes.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			// The closing stretch runs with no idling on either side.
			if (random_items > RANDOM_ITEMS * 4 / 5)
				idling_on = 1'b0;
			else
				idling_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: cols = 1;
				1: cols = 2;
				2: cols = 3;
				8: cols = $urandom_range(13, 40);
				default: cols = $urandom_range(4, 12);
			endcase
			rows = $urandom_range(1, 6);
			// Bits above the width field are don't-care and are randomized.
			width_data = CFG_DATA_W'($urandom);
			width_data[FW_W-1:0] = FW_W'(cols);
			if ($urandom_range(0, 1) == 0) begin
				set_frame(width_data, CFG_DATA_W'(rows));
			end else begin
				write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(rows));
				write_register(REG_FRAME_WIDTH, width_data);
			end
			if ($urandom_range(0, 7) == 0)
				write_register(REG_SPARE, CFG_DATA_W'($urandom));
			frames = $urandom_range(1, 3);
			repeat (frames) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						send_pixel(pick_cost(COST_RANDOM), pick_cost(COST_RANDOM),
							pick_cost(COST_RANDOM), 1'b1);
				cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cols * rows + cols) : 0;
				hold_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cols * rows) : 0;
				run_frame(cols, rows, COST_RANDOM, 12, cut_at, hold_at);
			end
		end

		// Drain the last results, allow the pipeline to settle, then judge.
		wait_idle(1'b1);
		if (mismatches == 0 && pending == 0)
			$display("cost_volume_box_sum_3x3_core verification clean");
		else
			$display("cost_volume_box_sum_3x3_core verification failed");
		$finish;
	end

endmodule
